// File: src/brbru_pkg.sv
// brbru_pkg: shared types, codes and sizes for the byte ring buffer
// no dependencies; used by brbru_ctrl and byte_ring_buffer_read_until
`default_nettype none

package brbru_pkg;

  localparam int DEPTH   = 256;
  localparam int MAX_RUN = 64;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SIZE_W = 9;
  localparam int CMP_W  = (IDX_W + 1 > SIZE_W) ? IDX_W + 1 : SIZE_W;
  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 7;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);

  // register index decoded from paddr
  localparam logic REG_SIZE_IN_USE = 1'b0;

  // opcodes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_UNTIL = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_OVERRUN = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ABSENT  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_SHORT   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] delimiter;
    logic [LEN_W-1:0]  max_len;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [CNT_W-1:0]  count;
  } res_t;

endpackage

`default_nettype wire

// File: src/byte_ring_buffer_read_until.sv
// byte_ring_buffer_read_until: top level with apb register, output register and assertions
// depends on brbru_pkg and brbru_ctrl
// write, read and status-only read-until: S_EMIT or S_POP, then the output register
// read-until: scan for the delimiter, then one byte per cycle while the output is free
// one transaction at a time: the sequencer must return to idle before the next accept
// reset: indices zero, size_in_use 256, output empty; byte store contents undefined
`default_nettype none

module byte_ring_buffer_read_until (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [2:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [brbru_pkg::OP_W-1:0]        opcode_i,
  input  wire logic [brbru_pkg::BYTE_W-1:0]      data_byte_i,
  input  wire logic [brbru_pkg::BYTE_W-1:0]      delimiter_i,
  input  wire logic [brbru_pkg::LEN_W-1:0]       max_len_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [brbru_pkg::STAT_W-1:0]      status_o,
  output logic      [brbru_pkg::BYTE_W-1:0]      data_out_o,
  output logic                                   last_o,
  output logic      [brbru_pkg::CNT_W-1:0]       count_o
);
  import brbru_pkg::*;

  logic [SIZE_W-1:0] size_q, size_d;
  logic [SIZE_W-1:0] wr_val;
  logic              cfg_we;
  logic              busy, accept, out_free;
  cmd_t              cmd;
  res_t              res;
  logic              out_valid_q;
  res_t              out_q;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SIZE_IN_USE);
  assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? 32'(size_q) : '0;
  assign wr_val = pwdata[SIZE_W-1:0];

  always_comb begin
    size_d = size_q;
    if (cfg_we) begin
      priority if (wr_val < SIZE_MIN) begin
        size_d = SIZE_MIN;
      end else if (CMP_W'(wr_val) > CMP_W'(DEPTH)) begin
        size_d = SIZE_W'(DEPTH);
      end else begin
        size_d = wr_val;
      end
    end
  end

  assign cmd.opcode    = opcode_i;
  assign cmd.data_byte = data_byte_i;
  assign cmd.delimiter = delimiter_i;
  assign cmd.max_len   = max_len_i;

  assign accept   = in_valid_i && !busy;
  assign out_free = !out_valid_q || !out_stall_i;

  brbru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (cmd),
    .cfg_clear_i (cfg_we),
    .size_i      (size_q),
    .out_free_i  (out_free),
    .busy_o      (busy),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      size_q <= size_d;
      if (out_free) begin
        out_valid_q <= res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign data_out_o  = out_q.data;
  assign last_o      = out_q.last;
  assign count_o     = out_q.count;

`ifndef SYNTHESIS
  // any real command leaves the block busy once it is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (opcode_i != OP_NONE)) |=> in_stall_o)
    else $error("input taken right after a command");

  // results without a byte always close the transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (count_o == '0)) |-> (last_o && (data_out_o == '0)))
    else $error("byte-less result not marked last");

  // error statuses carry no byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_OK)) |-> (count_o == '0))
    else $error("error status with a byte count");

  // run length capped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= CNT_W'(MAX_RUN)))
    else $error("run longer than the cap");
`endif

endmodule

`default_nettype wire

// File: src/brbru_ram.sv
// brbru_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module brbru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/brbru_ctrl.sv
// brbru_ctrl: sequencer, ring indices and byte store for the ring buffer
// depends on brbru_pkg and brbru_ram
`default_nettype none

module brbru_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire brbru_pkg::cmd_t             cmd_i,
  input  wire logic                        cfg_clear_i,
  input  wire logic [brbru_pkg::SIZE_W-1:0] size_i,
  input  wire logic                        out_free_i,
  output logic                             busy_o,
  output brbru_pkg::res_t                  res_o
);
  import brbru_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EMIT = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_POP  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [IDX_W-1:0]  wi_q, wi_d, ri_q, ri_d, p_q, p_d;
  logic              chk_q, chk_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [LEN_W-1:0]  lim_q, lim_d;
  logic [BYTE_W-1:0] delim_q, delim_d;
  logic [STAT_W-1:0] stat_q, stat_d;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  logic [IDX_W-1:0]  wi_next, ri_next;
  logic [CNT_W-1:0]  n_next;
  logic [LEN_W-1:0]  len_m1;
  logic              stop;

  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
                                           input logic [SIZE_W-1:0] sz);
    logic [CMP_W-1:0] nx;
    begin
      nx = CMP_W'(idx) + CMP_W'(1);
      return (nx >= CMP_W'(sz)) ? '0 : IDX_W'(nx);
    end
  endfunction

  brbru_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wi_q),
    .wdata_i (cmd_i.data_byte),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign wi_next = adv(wi_q, size_i);
  assign ri_next = adv(ri_q, size_i);
  assign n_next  = n_q + CNT_W'(1);
  assign len_m1  = cmd_i.max_len - LEN_W'(1);
  assign stop    = (mem_rdata == delim_q) || (CMP_W'(n_next) >= CMP_W'(lim_q)) ||
                   (ri_next == wi_q);

  always_comb begin
    state_d   = state_q;
    wi_d      = wi_q;
    ri_d      = ri_q;
    p_d       = p_q;
    chk_d     = 1'b0;
    n_d       = n_q;
    lim_d     = lim_q;
    delim_d   = delim_q;
    stat_d    = stat_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = ri_q;
    res_o     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          unique case (cmd_i.opcode)
            OP_WRITE: begin
              mem_we  = 1'b1;
              wi_d    = wi_next;
              state_d = S_EMIT;
              if (wi_next == ri_q) begin
                ri_d   = ri_next;
                stat_d = STAT_OVERRUN;
              end else begin
                stat_d = STAT_OK;
              end
            end
            OP_READ: begin
              if (ri_q == wi_q) begin
                stat_d  = STAT_EMPTY;
                state_d = S_EMIT;
              end else begin
                // single pop reuses the run path with a limit of one
                mem_re  = 1'b1;
                n_d     = '0;
                lim_d   = LEN_W'(1);
                delim_d = cmd_i.delimiter;
                state_d = S_POP;
              end
            end
            OP_UNTIL: begin
              delim_d = cmd_i.delimiter;
              lim_d   = (CMP_W'(len_m1) > CMP_W'(MAX_RUN)) ? LEN_W'(MAX_RUN) : len_m1;
              if (cmd_i.max_len < LEN_W'(2)) begin
                stat_d  = STAT_SHORT;
                state_d = S_EMIT;
              end else if (ri_q == wi_q) begin
                stat_d  = STAT_EMPTY;
                state_d = S_EMIT;
              end else begin
                p_d     = ri_q;
                state_d = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // reads are issued back to back; each byte is compared when its registered read data comes back
        if (chk_q && (mem_rdata == delim_q)) begin
          mem_re  = 1'b1;
          n_d     = '0;
          state_d = S_POP;
        end else if (p_q != wi_q) begin
          mem_re    = 1'b1;
          mem_raddr = p_q;
          p_d       = adv(p_q, size_i);
          chk_d     = 1'b1;
        end else begin
          stat_d  = STAT_ABSENT;
          state_d = S_EMIT;
        end
      end

      S_POP: begin
        if (out_free_i) begin
          res_o.valid  = 1'b1;
          res_o.status = STAT_OK;
          res_o.data   = mem_rdata;
          res_o.last   = stop;
          res_o.count  = n_next;
          ri_d         = ri_next;
          n_d          = n_next;
          if (stop) begin
            state_d = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ri_next;
          end
        end
      end

      S_EMIT: begin
        if (out_free_i) begin
          res_o.valid  = 1'b1;
          res_o.status = stat_q;
          res_o.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_clear_i) begin
      wi_d = '0;
      ri_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wi_q    <= '0;
      ri_q    <= '0;
      chk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      wi_q    <= wi_d;
      ri_q    <= ri_d;
      chk_q   <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    n_q     <= n_d;
    lim_q   <= lim_d;
    delim_q <= delim_d;
    stat_q  <= stat_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: bench/byte_ring_buffer_read_until_tb.sv
`timescale 1ns / 100ps
// byte_ring_buffer_read_until_tb: self-checking bench for the byte ring buffer with read-until
// depends on brbru_pkg and byte_ring_buffer_read_until; a scoreboard class predicts every result

module byte_ring_buffer_read_until_tb;
  import brbru_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 40;

  // register index of the unused upper word on the apb port
  localparam logic REG_SPARE = 1'b1;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [CNT_W-1:0]  count;
  } ring_result_t;

  class byte_ring_checker;
    logic [BYTE_W-1:0] cells[DEPTH];
    int unsigned       wr_idx;
    int unsigned       rd_idx;
    int unsigned       ring_len;
    ring_result_t      pending[$];
    int                errors;

    function new();
      wr_idx   = 0;
      rd_idx   = 0;
      ring_len = SIZE_RESET;
      errors   = 0;
    endfunction

    function int unsigned step(input int unsigned i);
      i++;
      if (i >= ring_len || i >= DEPTH) i = 0;
      return i;
    endfunction

    function void push(input logic [STAT_W-1:0] st, input logic [BYTE_W-1:0] d,
                       input logic l, input logic [CNT_W-1:0] c);
      ring_result_t r;
      r.status = st;
      r.data   = d;
      r.last   = l;
      r.count  = c;
      pending.push_back(r);
    endfunction

    // size register write; clamps and empties the ring
    function void write_reg(input logic [2:0] addr, input logic [31:0] value);
      int unsigned v;
      if (addr[2] != REG_SIZE_IN_USE) return;
      v = value[SIZE_W-1:0];
      if (v < SIZE_MIN) v = SIZE_MIN;
      if (v > DEPTH) v = DEPTH;
      ring_len = v;
      wr_idx   = 0;
      rd_idx   = 0;
    endfunction

    function void note_cmd(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] db,
                           input logic [BYTE_W-1:0] delim, input logic [LEN_W-1:0] mlen);
      logic [STAT_W-1:0] st;
      logic [BYTE_W-1:0] b;
      int unsigned       p;
      int unsigned       limit;
      int unsigned       n;
      bit                found;
      bit                stop;
      case (op)
        OP_WRITE: begin
          st = STAT_OK;
          cells[wr_idx] = db;
          wr_idx = step(wr_idx);
          if (wr_idx == rd_idx) begin
            rd_idx = step(rd_idx);
            st = STAT_OVERRUN;
          end
          push(st, '0, 1'b1, '0);
        end
        OP_READ: begin
          if (rd_idx == wr_idx) begin
            push(STAT_EMPTY, '0, 1'b1, '0);
          end else begin
            b = cells[rd_idx];
            rd_idx = step(rd_idx);
            push(STAT_OK, b, 1'b1, CNT_W'(1));
          end
        end
        OP_UNTIL: begin
          if (mlen < 2) begin
            push(STAT_SHORT, '0, 1'b1, '0);
          end else if (rd_idx == wr_idx) begin
            push(STAT_EMPTY, '0, 1'b1, '0);
          end else begin
            found = 0;
            p = rd_idx;
            while (p != wr_idx && !found) begin
              if (cells[p] == delim) found = 1;
              else p = step(p);
            end
            if (!found) begin
              push(STAT_ABSENT, '0, 1'b1, '0);
            end else begin
              limit = mlen - 1;
              if (limit > MAX_RUN) limit = MAX_RUN;
              n = 0;
              do begin
                b = cells[rd_idx];
                rd_idx = step(rd_idx);
                n++;
                stop = (b == delim) || (n >= limit) || (rd_idx == wr_idx);
                push(STAT_OK, b, stop, CNT_W'(n));
              end while (!stop);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(input logic [STAT_W-1:0] st, input logic [BYTE_W-1:0] d,
                      input logic l, input logic [CNT_W-1:0] c);
      ring_result_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result status=%0d data=%02h last=%b count=%0d",
                         st, d, l, c));
        return;
      end
      exp_r = pending.pop_front();
      if (st !== exp_r.status || d !== exp_r.data || l !== exp_r.last || c !== exp_r.count)
        report($sformatf("result mismatch: got st=%0d d=%02h l=%b c=%0d, want st=%0d d=%02h l=%b c=%0d",
                         st, d, l, c, exp_r.status, exp_r.data, exp_r.last, exp_r.count));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OP_W-1:0]   opcode_i;
  logic [BYTE_W-1:0] data_byte_i;
  logic [BYTE_W-1:0] delimiter_i;
  logic [LEN_W-1:0]  max_len_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [STAT_W-1:0] status_o;
  logic [BYTE_W-1:0] data_out_o;
  logic              last_o;
  logic [CNT_W-1:0]  count_o;

  byte_ring_checker sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int cycle_count;

  byte_ring_buffer_read_until dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .delimiter_i (delimiter_i),
    .max_len_i   (max_len_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .last_o      (last_o),
    .count_o     (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: long hold-off when requested, otherwise random stalls
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(status_o, data_out_o, last_o, count_o);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h0A;
      3: return 8'h5A;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return LEN_W'($urandom_range(1));
    else if (r < 30) return LEN_W'($urandom_range(65, 60));
    else return LEN_W'($urandom_range(12, 2));
  endfunction

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] db,
                          input logic [BYTE_W-1:0] delim, input logic [LEN_W-1:0] mlen);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i  = 1'b0;
      data_byte_i = BYTE_W'($urandom);
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    opcode_i    = op;
    data_byte_i = db;
    delimiter_i = delim;
    max_len_i   = mlen;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_cmd(op, db, delim, mlen);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(addr, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // drop valid, let every expected result come out, then let ignored opcodes settle
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random(input int n_items);
    int               done_items;
    int               pick;
    int               burst;
    logic [BYTE_W-1:0] mark;
    done_items = 0;
    while (done_items < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // bytes ending in a marker, then a read-until on that marker
        burst = $urandom_range(8, 1);
        mark  = pick_byte();
        repeat (burst - 1) send_cmd(OP_WRITE, pick_byte(), BYTE_W'($urandom), pick_len());
        send_cmd(OP_WRITE, mark, BYTE_W'($urandom), pick_len());
        send_cmd(OP_UNTIL, BYTE_W'($urandom), mark, pick_len());
        done_items += burst + 1;
      end else if (pick < 60) begin
        send_cmd(OP_READ, BYTE_W'($urandom), BYTE_W'($urandom), pick_len());
        done_items++;
      end else if (pick < 85) begin
        send_cmd(OP_UNTIL, BYTE_W'($urandom), pick_byte(), pick_len());
        done_items++;
      end else if (pick < 92) begin
        send_cmd(OP_NONE, BYTE_W'($urandom), BYTE_W'($urandom), LEN_W'($urandom_range(65)));
      end else begin
        send_cmd(OP_W'($urandom_range(2)), BYTE_W'($urandom), BYTE_W'($urandom),
                 LEN_W'($urandom_range(65)));
        done_items++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    opcode_i      = OP_NONE;
    data_byte_i   = '0;
    delimiter_i   = '0;
    max_len_i     = '0;
    out_stall_i   = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, ring at its reset length
    send_cmd(OP_READ, 8'h00, 8'h00, 7'd0);
    send_cmd(OP_UNTIL, 8'h00, 8'h00, 7'd5);
    send_cmd(OP_UNTIL, 8'hFF, 8'hFF, 7'd0);
    send_cmd(OP_UNTIL, 8'h00, 8'h00, 7'd1);
    send_cmd(OP_NONE, 8'hFF, 8'hFF, 7'd65);
    send_cmd(OP_WRITE, 8'h00, 8'hFF, 7'd65);
    send_cmd(OP_WRITE, 8'hFF, 8'h00, 7'd0);
    send_cmd(OP_WRITE, 8'h41, 8'h00, 7'd0);
    send_cmd(OP_WRITE, 8'h0A, 8'h00, 7'd0);
    send_cmd(OP_WRITE, 8'h42, 8'h00, 7'd0);
    send_cmd(OP_UNTIL, 8'h00, 8'h77, 7'd65);
    send_cmd(OP_UNTIL, 8'h00, 8'h0A, 7'd65);
    send_cmd(OP_UNTIL, 8'h00, 8'h42, 7'd1);
    send_cmd(OP_READ, 8'h00, 8'h00, 7'd0);
    send_cmd(OP_READ, 8'h00, 8'h00, 7'd0);
    send_cmd(OP_WRITE, 8'h01, 8'h00, 7'd0);
    send_cmd(OP_WRITE, 8'h02, 8'h00, 7'd0);
    send_cmd(OP_WRITE, 8'h03, 8'h00, 7'd0);
    send_cmd(OP_UNTIL, 8'h00, 8'h03, 7'd2);
    send_cmd(OP_UNTIL, 8'h00, 8'h03, 7'd3);
    wait_drained();

    // size below the minimum clamps to two cells, one byte of storage
    apb_write({REG_SIZE_IN_USE, 2'b00}, 32'd0);
    send_cmd(OP_WRITE, 8'hAA, 8'h00, 7'd0);
    send_cmd(OP_WRITE, 8'hBB, 8'h00, 7'd0);
    send_cmd(OP_READ, 8'h00, 8'h00, 7'd0);
    send_cmd(OP_READ, 8'h00, 8'h00, 7'd0);
    send_cmd(OP_WRITE, 8'hCC, 8'h00, 7'd0);
    send_cmd(OP_UNTIL, 8'h00, 8'hCC, 7'd64);
    wait_drained();

    send_idle_pct = 29;
    recv_idle_pct = 79;
    apb_write({REG_SIZE_IN_USE, 2'b00}, {23'($urandom_range(32'h7F_FFFF)), 9'd5});
    run_random(14);
    wait_drained();

    // the spare register is ignored, so the ring keeps its length and contents
    apb_write({REG_SPARE, 2'b00}, $urandom);
    send_idle_pct = 79;
    recv_idle_pct = 29;
    send_cmd(OP_UNTIL, 8'h00, pick_byte(), 7'd65);
    wait_drained();

    apb_write({REG_SIZE_IN_USE, 2'b00}, {23'($urandom_range(32'h7F_FFFF)), 9'd17});
    run_random(14);
    wait_drained();

    // oversize clamps to the full depth; fill past the wrap, starting with the output held off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apb_write({REG_SIZE_IN_USE, 2'b00}, {23'($urandom_range(32'h7F_FFFF)), 9'h1FF});
    hold_left = 400;
    repeat (DEPTH + 4) send_cmd(OP_WRITE, pick_byte(), BYTE_W'($urandom), pick_len());
    send_cmd(OP_UNTIL, 8'h00, 8'h0A, 7'd65);
    run_random(6);
    wait_drained();

    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
